@@ hw/rtl/bhpq_pkg.sv @@
// shared constants and types of the binary heap priority queue
package bhpq_pkg;

    localparam int DEPTH_DEF        = 1024;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int ITEM_KEY_W = 32;
    localparam int ITEM_PAY_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int CFG_CAP_W  = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd1;

    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic we;
        logic re0;
        logic re1;
    } ram_ctl_t;

endpackage

@@ hw/rtl/bhpq_req_if.sv @@
// request channel of the heap queue
interface bhpq_req_if import bhpq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [ITEM_KEY_W-1:0] item_key;
    logic [ITEM_PAY_W-1:0]        item_payload;

    modport source (output valid, opcode, item_key, item_payload, input ready);
    modport sink (input valid, opcode, item_key, item_payload, output ready);
endinterface

@@ hw/rtl/bhpq_rsp_if.sv @@
// response channel of the heap queue
interface bhpq_rsp_if import bhpq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [ITEM_KEY_W-1:0] out_key;
    logic [ITEM_PAY_W-1:0]        out_payload;
    logic [STATUS_W-1:0]          status;
    logic                         moved;
    logic [COUNT_W-1:0]           count_after;

    modport source (output valid, out_key, out_payload, status, moved, count_after,
                    input ready);
    modport sink (input valid, out_key, out_payload, status, moved, count_after,
                  output ready);
endinterface

@@ hw/rtl/bhpq_ram.sv @@
// heap entry store: one write port, two registered read ports
module bhpq_ram import bhpq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = KEY_BITS_DEF + PAYLOAD_BITS_DEF
) (
    input  logic                     clk,
    input  ram_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re0)
        begin
            rdata0 <= mem[raddr0];
        end
        if (ctl.re1)
        begin
            rdata1 <= mem[raddr1];
        end
    end

endmodule

@@ hw/rtl/binary_heap_priority_queue.sv @@
// binary heap priority queue: sequencer, shared key comparator and entry store
//
//  channel   dir  handshake      payload
//  cfg_*     in   cfg_we only    cfg_idx, cfg_data
//  req       in   valid/ready    opcode, item_key, item_payload
//  rsp       out  valid/ready    out_key, out_payload, status, moved, count_after
//
// insert: the new item climbs from the new last slot, one S_UP_CHK/S_UP_CMP pass per level;
// extract: S_EX_RD reads the root and the last entry, S_EX_LATCH takes them, then the last entry sinks
// with one S_DN_CHK/S_DN_CL/S_DN_CR pass per level; refused items go straight to S_FIN.
// every level costs one read of store port 0 and one comparator pass going up, one read
// of both store ports and two comparator passes going down, so the walk length sets the time taken.
// rst_n clears the entry count and config; the store itself is never cleared.
// a finished result waits in the rsp register; the next result holds in S_FIN until it leaves.
module binary_heap_priority_queue import bhpq_pkg::*; #(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bhpq_req_if.sink              req,
    bhpq_rsp_if.source            rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > CFG_CAP_W) ? CNT_W : CFG_CAP_W;
    localparam int EW    = KEY_BITS + PAYLOAD_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_RD,
        S_EX_LATCH,
        S_DN_CHK,
        S_DN_CL,
        S_DN_CR,
        S_FIN
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      slot_reg, slot_next;
    logic [EW-1:0]         cur_reg, cur_next;
    logic [EW-1:0]         best_reg, best_next;
    logic                  best_child_reg, best_child_next;
    logic [KEY_BITS-1:0]   res_key_reg, res_key_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    status_t               res_status_reg, res_status_next;
    logic                  moved_reg, moved_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ITEM_KEY_W-1:0] out_key_reg, out_key_next;
    logic [ITEM_PAY_W-1:0] out_pay_reg, out_pay_next;
    status_t               out_status_reg, out_status_next;
    logic                  out_moved_reg, out_moved_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_load;

    logic                  order_mode_reg;
    logic [CFG_CAP_W-1:0]  cap_limit_reg;

    ram_ctl_t              ram_ctl;
    logic [CNT_W-1:0]      wr_slot;
    logic [EW-1:0]         wr_data;
    logic [AW-1:0]         raddr0, raddr1;
    logic [EW-1:0]         rdata0, rdata1;

    logic [KEY_BITS-1:0]   cmp_a, cmp_b;
    logic                  cmp_beats;

    logic [CW-1:0]         cap_eff;
    logic                  heap_full;
    logic [CNT_W:0]        left_slot, right_slot, count_ext;
    logic [CNT_W:0]        left_m1;
    logic [CNT_W-1:0]      parent_slot, parent_m1, last_m1, wr_m1;
    logic                  right_ok;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= MODE_MIN;
            cap_limit_reg  <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_ORDER_MODE: order_mode_reg <= cfg_data[0];
                CFG_CAPACITY:   cap_limit_reg  <= cfg_data[CFG_CAP_W-1:0];
            endcase
        end
    end

    // shared key comparator: true when a belongs above b
    always_comb
    begin
        if (order_mode_reg == MODE_MAX)
        begin
            cmp_beats = $signed(cmp_a) > $signed(cmp_b);
        end
        else
        begin
            cmp_beats = $signed(cmp_a) < $signed(cmp_b);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_DN_CL:
            begin
                cmp_a = rdata0[EW-1:PAYLOAD_BITS];
                cmp_b = cur_reg[EW-1:PAYLOAD_BITS];
            end
            S_DN_CR:
            begin
                cmp_a = rdata1[EW-1:PAYLOAD_BITS];
                cmp_b = best_reg[EW-1:PAYLOAD_BITS];
            end
            default:
            begin
                cmp_a = cur_reg[EW-1:PAYLOAD_BITS];
                cmp_b = rdata0[EW-1:PAYLOAD_BITS];
            end
        endcase
    end

    assign cap_eff    = (CW'(cap_limit_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_limit_reg);
    assign heap_full  = CW'(count_reg) >= cap_eff;
    assign count_ext  = {1'b0, count_reg};
    assign left_slot  = {slot_reg, 1'b0};
    assign right_slot = {slot_reg, 1'b1};
    assign left_m1    = left_slot - 1'b1;
    assign right_ok   = right_slot <= count_ext;
    assign parent_slot = slot_reg >> 1;
    assign parent_m1  = parent_slot - 1'b1;
    assign last_m1    = count_reg - 1'b1;
    assign wr_m1      = wr_slot - 1'b1;
    assign out_load   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        best_child_next = best_child_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        res_status_next = res_status_reg;
        moved_next      = moved_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_key_next    = out_key_reg;
        out_pay_next    = out_pay_reg;
        out_status_next = out_status_reg;
        out_moved_next  = out_moved_reg;
        out_count_next  = out_count_reg;
        ram_ctl         = '0;
        wr_slot         = slot_reg;
        wr_data         = cur_reg;
        raddr0          = parent_m1[AW-1:0];
        raddr1          = last_m1[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_key_next    = '0;
                    res_pay_next    = '0;
                    res_status_next = ST_DONE;
                    moved_next      = 1'b0;
                    if (req.opcode == OP_INSERT)
                    begin
                        if (heap_full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            slot_next  = count_reg + 1'b1;
                            cur_next   = {req.item_key[KEY_BITS-1:0],
                                          req.item_payload[PAYLOAD_BITS-1:0]};
                            state_next = S_UP_CHK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_EX_RD;
                    end
                end
            end
            S_UP_CHK:
            begin
                if (slot_reg == CNT_W'(1))
                begin
                    ram_ctl.we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_ctl.re0 = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_ctl.we = 1'b1;
                if (cmp_beats)
                begin
                    wr_data    = rdata0;
                    slot_next  = parent_slot;
                    moved_next = 1'b1;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EX_RD:
            begin
                ram_ctl.re0 = 1'b1;
                ram_ctl.re1 = 1'b1;
                raddr0      = '0;
                state_next  = S_EX_LATCH;
            end
            S_EX_LATCH:
            begin
                res_key_next = rdata0[EW-1:PAYLOAD_BITS];
                res_pay_next = rdata0[PAYLOAD_BITS-1:0];
                cur_next     = rdata1;
                count_next   = count_reg - 1'b1;
                slot_next    = CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DN_CHK;
                end
            end
            S_DN_CHK:
            begin
                if (left_slot > count_ext)
                begin
                    ram_ctl.we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_ctl.re0 = 1'b1;
                    ram_ctl.re1 = 1'b1;
                    raddr0      = left_m1[AW-1:0];
                    raddr1      = right_ok ? left_slot[AW-1:0] : left_m1[AW-1:0];
                    state_next  = S_DN_CL;
                end
            end
            S_DN_CL:
            begin
                best_child_next = cmp_beats;
                best_next       = cmp_beats ? rdata0 : cur_reg;
                state_next      = S_DN_CR;
            end
            S_DN_CR:
            begin
                ram_ctl.we = 1'b1;
                if (right_ok && cmp_beats)
                begin
                    wr_data    = rdata1;
                    slot_next  = right_slot[CNT_W-1:0];
                    state_next = S_DN_CHK;
                end
                else if (best_child_reg)
                begin
                    wr_data    = best_reg;
                    slot_next  = left_slot[CNT_W-1:0];
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = ITEM_KEY_W'($signed(res_key_reg));
                    out_pay_next    = ITEM_PAY_W'(res_pay_reg);
                    out_status_next = res_status_reg;
                    out_moved_next  = moved_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            slot_reg       <= '0;
            cur_reg        <= '0;
            best_reg       <= '0;
            best_child_reg <= 1'b0;
            res_key_reg    <= '0;
            res_pay_reg    <= '0;
            res_status_reg <= ST_DONE;
            moved_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_key_reg    <= '0;
            out_pay_reg    <= '0;
            out_status_reg <= ST_DONE;
            out_moved_reg  <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            slot_reg       <= slot_next;
            cur_reg        <= cur_next;
            best_reg       <= best_next;
            best_child_reg <= best_child_next;
            res_key_reg    <= res_key_next;
            res_pay_reg    <= res_pay_next;
            res_status_reg <= res_status_next;
            moved_reg      <= moved_next;
            out_valid_reg  <= out_valid_next;
            out_key_reg    <= out_key_next;
            out_pay_reg    <= out_pay_next;
            out_status_reg <= out_status_next;
            out_moved_reg  <= out_moved_next;
            out_count_reg  <= out_count_next;
        end
    end

    bhpq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk    (clk),
        .ctl    (ram_ctl),
        .waddr  (wr_m1[AW-1:0]),
        .wdata  (wr_data),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.out_key     = out_key_reg;
    assign rsp.out_payload = out_pay_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.moved       = out_moved_reg;
    assign rsp.count_after = out_count_reg;

    // store writes stay inside the live part of the heap
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.we |-> (wr_slot != '0) && (wr_slot <= count_reg))
        else $error("heap write outside live entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond store depth");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && out_load |=>
            (out_status_reg == ST_DONE) ||
            ((out_key_reg == '0) && (out_pay_reg == '0) && !out_moved_reg))
        else $error("refused item carries data");

    a_refused_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && req.valid && (req.opcode == OP_INSERT) && heap_full |=>
            count_reg == $past(count_reg))
        else $error("refused insert changed the count");

endmodule
